// File: rtl/core/sorted_priority_queue_core_defines.svh
// Assertion macros used by the sorted priority queue checker.
`ifndef SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Checks a property on every clock edge outside reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checks a property on every clock edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// Package with the types and constants of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Number of cells in the row, and the widths that follow from it.
  localparam int unsigned Depth = 16;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  // Fixed field widths.
  localparam int unsigned DataW   = 32;
  localparam int unsigned OccW    = 5;
  localparam int unsigned StatusW = 2;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // One held entry.
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic signed [DataW-1:0] prio;
  } entry_t;

  // Command broadcast to every cell of the row.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/spq_ifs.sv
// Valid/ready channel interfaces of the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               opcode;
  logic signed [spq_pkg::DataW-1:0]   item_value;
  logic signed [spq_pkg::DataW-1:0]   item_priority;

  modport source (output valid, output opcode, output item_value, output item_priority,
                  input ready);
  modport sink   (input valid, input opcode, input item_value, input item_priority,
                  output ready);
endinterface

interface spq_out_if;
  logic                               valid;
  logic                               ready;
  logic [spq_pkg::StatusW-1:0]        status;
  logic signed [spq_pkg::DataW-1:0]   out_value;
  logic signed [spq_pkg::DataW-1:0]   out_priority;
  logic [spq_pkg::OccW-1:0]           occupancy;

  modport source (output valid, output status, output out_value, output out_priority,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_value, input out_priority,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spq_cell.sv
// One cell of the sorted row: holds an entry and shifts with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module spq_cell (
  input  logic                clk_i,
  input  spq_pkg::cell_ctl_t  ctl_i,
  input  logic                occupied_i,
  input  logic                prev_take_i,
  input  spq_pkg::entry_t     prev_entry_i,
  input  spq_pkg::entry_t     next_entry_i,
  output logic                take_o,
  output spq_pkg::entry_t     entry_o
);
  import spq_pkg::*;

  entry_t entry_q, entry_d;

  // The cell gives way to the new entry when it is empty or holds a strictly
  // lower priority; equal priorities stay ahead, keeping arrival order.
  assign take_o = !occupied_i || (entry_q.prio < ctl_i.new_entry.prio);

  // On enqueue the first cell that gives way takes the new entry and the
  // ones behind it take their predecessor; on dequeue all move forward.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.enq && take_o) begin
      entry_d = prev_take_i ? prev_entry_i : ctl_i.new_entry;
    end else if (ctl_i.deq) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// File: rtl/core/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: cell row, fill count and result register.
//
// Usage: requests arrive on req_i (opcode 0 enqueues item_value with
// item_priority, opcode 1 dequeues the highest-priority entry). Each request
// yields exactly one result on rsp_o carrying status, the dequeued value and
// priority (zero for enqueues and failed dequeues) and the occupancy after
// the operation. Entries of equal priority leave in arrival order.
// A full queue drops an enqueue with status 1; an empty queue answers a
// dequeue with status 2.
// The result is registered and valid in the cycle after the request transaction.
// Throughput: one request per cycle unless the result stalls; every cell of the
// row compares its own priority with the incoming one in the same cycle and
// shifts in one step. Reset clears the fill count and the result valid flag,
// not the cells or the result payload. While the receiver stalls, the
// pending result holds and req_i.ready stays low until the result is taken.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  spq_in_if.sink     req_i,
  spq_out_if.source  rsp_o
);
  import spq_pkg::*;

  logic                accept;
  cell_ctl_t           ctl;
  logic [CntW-1:0]     count_q, count_d;
  logic                take_w  [Depth];
  entry_t              entry_w [Depth];

  logic                out_valid_q;
  status_e             status_q, status_d;
  entry_t              result_q, result_d;
  logic [OccW-1:0]     occ_q, occ_d;

  // Take a request whenever the result register is free or being drained.
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Decode the request into the row command, the next fill count and the result.
  always_comb begin
    ctl.enq             = 1'b0;
    ctl.deq             = 1'b0;
    ctl.new_entry.value = req_i.item_value;
    ctl.new_entry.prio  = req_i.item_priority;
    count_d             = count_q;
    status_d            = ST_DONE;
    result_d            = '0;
    unique case (op_e'(req_i.opcode))
      OP_ENQ: begin
        if (count_q == CntW'(Depth)) begin
          status_d = ST_FULL;
        end else begin
          ctl.enq = accept;
          count_d = count_q + CntW'(1);
        end
      end
      OP_DEQ: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          ctl.deq  = accept;
          result_d = entry_w[0];
          count_d  = count_q - CntW'(1);
        end
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
    occ_d = OccW'(count_d);
  end

  // The row of cells; the first has no predecessor, the last no successor.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic   prev_take;
    entry_t prev_entry;
    entry_t next_entry;

    if (g == 0) begin : g_head
      assign prev_take  = 1'b0;
      assign prev_entry = ctl.new_entry;
    end else begin : g_body
      assign prev_take  = take_w[g-1];
      assign prev_entry = entry_w[g-1];
    end

    if (g == Depth - 1) begin : g_tail
      assign next_entry = entry_w[g];
    end else begin : g_inner
      assign next_entry = entry_w[g+1];
    end

    spq_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occupied_i   (count_q > CntW'(g)),
      .prev_take_i  (prev_take),
      .prev_entry_i (prev_entry),
      .next_entry_i (next_entry),
      .take_o       (take_w[g]),
      .entry_o      (entry_w[g])
    );
  end

  // Fill count and result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted request.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      result_q <= result_d;
      occ_q    <= occ_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = status_q;
  assign rsp_o.out_value    = result_q.value;
  assign rsp_o.out_priority = result_q.prio;
  assign rsp_o.occupancy    = occ_q;

endmodule

`default_nettype wire

// File: rtl/core/spq_checker.sv
// Port-level checker for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_priority_queue_core_defines.svh"

module spq_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [spq_pkg::StatusW-1:0]      status_i,
  input  logic signed [spq_pkg::DataW-1:0] out_value_i,
  input  logic signed [spq_pkg::DataW-1:0] out_priority_i,
  input  logic [spq_pkg::OccW-1:0]         occupancy_i
);
  import spq_pkg::*;

  // Every request transaction produces a result in the following cycle.
  `SPQ_ASSERT(a_result_follows, in_valid_i && in_ready_i |=> out_valid_i, "request gave no result")

  // A failed dequeue reports an empty queue and zero payload.
  `SPQ_ASSERT(a_empty_result, out_valid_i && (status_i == ST_EMPTY) |-> (occupancy_i == '0) && (out_value_i == '0) && (out_priority_i == '0), "bad empty result")

  // A dropped enqueue reports a full queue.
  `SPQ_ASSERT(a_full_result, out_valid_i && (status_i == ST_FULL) |-> (occupancy_i == OccW'(Depth)) && (out_value_i == '0), "bad full result")

  // A stalled result holds its status, value and occupancy.
  `SPQ_ASSERT(a_stall_hold, out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(out_value_i) && $stable(occupancy_i), "result changed under stall")

  // Once reset has been seen at an edge, no result is shown at the next edge.
  `SPQ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_i, "result valid in reset")

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (req_i.valid),
  .in_ready_i     (req_i.ready),
  .out_valid_i    (rsp_o.valid),
  .out_ready_i    (rsp_o.ready),
  .status_i       (rsp_o.status),
  .out_value_i    (rsp_o.out_value),
  .out_priority_i (rsp_o.out_priority),
  .occupancy_i    (rsp_o.occupancy)
);

`default_nettype wire
